>>> rtl/tbcs_pkg.sv
// ----------------------------------------------------------------------------
// tbcs_pkg
// Shared types and constants of the text buffer with cursor and scroll.
// ----------------------------------------------------------------------------
`default_nettype none

package tbcs_pkg;

  localparam int ROWS_DEF = 4;
  localparam int COLS_DEF = 21;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 2;
  localparam int COL_W  = 5;
  localparam int POS_W  = 7;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ
  } tbcs_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT,
    ST_FILL,
    ST_READ,
    ST_RESP
  } tbcs_state_e;

  typedef struct packed {
    tbcs_op_e          op;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } tbcs_entry_t;

endpackage

`default_nettype wire

>>> rtl/text_buffer_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_buffer_cursor_scroll
// Character-cell text buffer with linear cursor, newline and row scroll.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------------
//   in      | request   | in_valid_i / in_stall_o   | command, char_code, row, col
//   out     | result    | out_valid_o / out_stall_i | cell_char, cursor_pos
//
// A request passes through the front register and the queue; the engine
// offers the result of a clear, a spare command, a blank-row read or a
// newline that writes nothing straight from its idle state, and of a put or
// a written-row read after an ST_PUT or ST_READ state. Writing a character
// to a row left blank by a scroll or clear first fills it with spaces, and a
// newline on a written row fills the rest of it, cell by cell through the
// single write port of the cell memory. The engine idles once its result leaves.
// Reset leaves every row marked blank, so the buffer reads as spaces at once.
// A stalled result holds the engine; the front end keeps taking requests until
// the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module text_buffer_cursor_scroll import tbcs_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [ROW_W-1:0]  cell_row_i,
  input  wire logic [COL_W-1:0]  cell_col_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CHAR_W-1:0]      cell_char_o,
  output logic [POS_W-1:0]       cursor_pos_o
);

  logic        push_valid;
  logic        q_full;
  tbcs_entry_t push_entry;
  logic        pop;
  logic        pop_valid;
  tbcs_entry_t pop_entry;

  tbcs_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .char_code_i (char_code_i),
    .cell_row_i  (cell_row_i),
    .cell_col_i  (cell_col_i),
    .push_valid_o(push_valid),
    .push_full_i (q_full),
    .push_entry_o(push_entry)
  );

  tbcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_entry_i(push_entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_entry_o (pop_entry)
  );

  tbcs_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cell_char_o (cell_char_o),
    .cursor_pos_o(cursor_pos_o)
  );

endmodule

`default_nettype wire

>>> rtl/tbcs_front.sv
// ----------------------------------------------------------------------------
// tbcs_front
// Accepts requests, decodes them into buffer operations and hands them on.
// ----------------------------------------------------------------------------
`default_nettype none

module tbcs_front import tbcs_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [ROW_W-1:0]  cell_row_i,
  input  wire logic [COL_W-1:0]  cell_col_i,
  output logic                   push_valid_o,
  input  wire logic              push_full_i,
  output tbcs_entry_t            push_entry_o
);

  logic        valid_q, valid_d;
  tbcs_entry_t entry_q, entry_d;
  logic        accept;
  logic        push;
  logic        rd_ok;
  tbcs_op_e    op;

  assign in_stall_o   = valid_q && push_full_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign push         = valid_q && !push_full_i;
  assign push_valid_o = valid_q;
  assign push_entry_o = entry_q;

  always_comb begin
    rd_ok = (32'(cell_row_i) < ROWS) && (32'(cell_col_i) < COLS);
    case (command_i)
      CMD_WRITE: op = (char_code_i == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
      CMD_CLEAR: op = OP_CLEAR;
      CMD_READ:  op = rd_ok ? OP_READ : OP_NOP;
      default:   op = OP_NOP;
    endcase
    entry_d.op        = op;
    entry_d.char_code = char_code_i;
    entry_d.row       = cell_row_i;
    entry_d.col       = cell_col_i;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tbcs_queue.sv
// ----------------------------------------------------------------------------
// tbcs_queue
// Short first-in first-out queue of decoded operations.
// ----------------------------------------------------------------------------
`default_nettype none

module tbcs_queue import tbcs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  tbcs_entry_t push_entry_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       pop_valid_o,
  output tbcs_entry_t pop_entry_o
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNTW = $clog2(QDEPTH + 1);

  tbcs_entry_t       entries_q [QDEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o      = (count_q == CNTW'(QDEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_entry_o = entries_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tbcs_back.sv
// ----------------------------------------------------------------------------
// tbcs_back
// Executes buffer operations: cell memory, circular row window, cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module tbcs_back import tbcs_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              pop_valid_i,
  input  tbcs_entry_t            pop_entry_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CHAR_W-1:0]      cell_char_o,
  output logic [POS_W-1:0]       cursor_pos_o
);

  localparam int CELLS = ROWS * COLS;
  localparam int RW    = $clog2(ROWS);
  localparam int SW    = RW + 1;
  localparam int RCW   = $clog2(ROWS + 1);
  localparam int CW    = $clog2(COLS);
  localparam int LW    = $clog2(CELLS + 1);
  localparam int AW    = $clog2(CELLS);

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                             input logic [RW-1:0] r);
    logic [SW-1:0] s;
    s = {1'b0, top} + {1'b0, r};
    if (s >= SW'(ROWS)) begin
      s = s - SW'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                              input logic [CW-1:0] col);
    return AW'(prow) * AW'(COLS) + AW'(col);
  endfunction

  tbcs_state_e       state_q, state_d;
  tbcs_entry_t       ent_q, ent_d;
  logic [RW-1:0]     top_q, top_d;
  logic [RCW-1:0]    row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic [LW-1:0]     lin_q, lin_d;
  logic [ROWS-1:0]   valid_q, valid_d;
  logic [CW-1:0]     fcol_q, fcol_d;
  logic              then_put_q, then_put_d;
  logic [CHAR_W-1:0] cell_q, cell_d;
  logic [CHAR_W-1:0] rdata_q;
  logic [CHAR_W-1:0] mem [CELLS];

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [RW-1:0]     cprow, rprow, top_inc;
  logic              past_end;

  assign cprow    = phys_row(top_q, RW'(row_q));
  assign rprow    = phys_row(top_q, RW'(pop_entry_i.row));
  assign top_inc  = (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
  assign past_end = (row_q == RCW'(ROWS));

  assign out_valid_o  = (state_q == ST_RESP);
  assign cell_char_o  = cell_q;
  assign cursor_pos_o = POS_W'(lin_q);

  always_comb begin
    state_d    = state_q;
    ent_d      = ent_q;
    top_d      = top_q;
    row_d      = row_q;
    col_d      = col_q;
    lin_d      = lin_q;
    valid_d    = valid_q;
    fcol_d     = fcol_q;
    then_put_d = then_put_q;
    cell_d     = cell_q;
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cell_addr(cprow, fcol_q);
    mem_wdata  = SPACE_CODE;
    mem_re     = 1'b0;
    mem_raddr  = cell_addr(rprow, CW'(pop_entry_i.col));
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          pop_o  = 1'b1;
          ent_d  = pop_entry_i;
          cell_d = '0;
          case (pop_entry_i.op)
            OP_CLEAR: begin
              valid_d = '0;
              top_d   = '0;
              row_d   = '0;
              col_d   = '0;
              lin_d   = '0;
              state_d = ST_RESP;
            end
            OP_READ: begin
              if (valid_q[rprow]) begin
                mem_re  = 1'b1;
                state_d = ST_READ;
              end else begin
                cell_d  = SPACE_CODE;
                state_d = ST_RESP;
              end
            end
            OP_PUT: begin
              if (past_end) begin
                top_d          = top_inc;
                valid_d[top_q] = 1'b0;
                row_d          = RCW'(ROWS - 1);
                col_d          = '0;
                lin_d          = LW'(CELLS - COLS);
              end
              state_d = ST_PUT;
            end
            OP_NEWLINE: begin
              if (past_end) begin
                top_d          = top_inc;
                valid_d[top_q] = 1'b0;
                state_d        = ST_RESP;
              end else if (!valid_q[cprow]) begin
                row_d   = row_q + 1'b1;
                col_d   = '0;
                lin_d   = lin_q + LW'(COLS) - LW'(col_q);
                state_d = ST_RESP;
              end else begin
                fcol_d     = col_q;
                then_put_d = 1'b0;
                state_d    = ST_FILL;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_PUT: begin
        if (!valid_q[cprow]) begin
          fcol_d     = '0;
          then_put_d = 1'b1;
          state_d    = ST_FILL;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(cprow, col_q);
          mem_wdata = ent_q.char_code;
          if (col_q == CW'(COLS - 1)) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
          lin_d   = lin_q + 1'b1;
          state_d = ST_RESP;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (fcol_q == CW'(COLS - 1)) begin
          if (then_put_q) begin
            valid_d[cprow] = 1'b1;
            state_d        = ST_PUT;
          end else begin
            row_d   = row_q + 1'b1;
            col_d   = '0;
            lin_d   = lin_q + LW'(COLS) - LW'(col_q);
            state_d = ST_RESP;
          end
        end else begin
          fcol_d = fcol_q + 1'b1;
        end
      end
      ST_READ: begin
        cell_d  = rdata_q;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      top_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
      lin_q      <= '0;
      valid_q    <= '0;
      fcol_q     <= '0;
      then_put_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      top_q      <= top_d;
      row_q      <= row_d;
      col_q      <= col_d;
      lin_q      <= lin_d;
      valid_q    <= valid_d;
      fcol_q     <= fcol_d;
      then_put_q <= then_put_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    cell_q <= cell_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  a_lin_matches_rowcol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lin_q == LW'(row_q) * LW'(COLS) + LW'(col_q))
    else $error("linear cursor out of step with row and column");

  a_past_end_col_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q == RCW'(ROWS)) |-> (col_q == '0))
    else $error("cursor past end with nonzero column");

  a_fill_before_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && then_put_q) |-> !valid_q[cprow])
    else $error("row fill started on a row already valid");

  a_read_follows_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> ($past(state_q) == ST_IDLE))
    else $error("read data stage entered without a read issue");

endmodule

`default_nettype wire

>>> test/text_buffer_cursor_scroll_tb.sv
// ----------------------------------------------------------------------------
// text_buffer_cursor_scroll_tb
// Self-checking bench for the text buffer with cursor and scroll. A scoreboard
// tracks the cell grid and cursor for every accepted request and compares each
// reply field by field. Directed requests cover field extremes, newline fill,
// scroll, newline past the end, out-of-range reads, clear and the spare
// command. Random traffic follows, mostly text with newlines and reads. Both
// sides idle at random.
// ----------------------------------------------------------------------------
module text_buffer_cursor_scroll_tb import tbcs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = ROWS_DEF;
  localparam int COLS = COLS_DEF;
  localparam int CELLS = ROWS * COLS;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int RANDOM_REQUESTS = 1630;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [POS_W-1:0]  cursor_pos;
  } screen_reply_t;

  class text_screen_tracker;
    logic [CHAR_W-1:0] grid [CELLS];
    int unsigned       cursor;
    screen_reply_t     expected_replies [$];
    int                errors;

    function new();
      foreach (grid[i]) grid[i] = SPACE_CODE;
      cursor = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void put_cell(logic [CHAR_W-1:0] code);
      if (cursor >= CELLS) begin
        for (int i = 0; i < CELLS - COLS; i++) grid[i] = grid[i + COLS];
        cursor = CELLS - COLS;
        for (int i = CELLS - COLS; i < CELLS; i++) grid[i] = SPACE_CODE;
      end
      grid[cursor] = code;
      cursor++;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] code,
                               logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
      screen_reply_t reply;
      int unsigned   fill_col;
      reply.cell_char = '0;
      case (cmd)
        CMD_WRITE: begin
          if (code == NEWLINE_CODE) begin
            fill_col = cursor % COLS;
            for (int c = int'(fill_col); c < COLS; c++) put_cell(SPACE_CODE);
          end else begin
            put_cell(code);
          end
        end
        CMD_CLEAR: begin
          foreach (grid[i]) grid[i] = SPACE_CODE;
          cursor = 0;
        end
        CMD_READ: begin
          if (row < ROWS && col < COLS) reply.cell_char = grid[row * COLS + col];
        end
        default: ;
      endcase
      reply.cursor_pos = POS_W'(cursor);
      expected_replies.push_back(reply);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 200) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_reply(logic [CHAR_W-1:0] cell_char, logic [POS_W-1:0] cursor_pos);
      screen_reply_t want;
      if (expected_replies.size() == 0) begin
        report($sformatf("unexpected reply char=%0d pos=%0d", cell_char, cursor_pos));
      end else begin
        want = expected_replies.pop_front();
        if (cell_char !== want.cell_char)
          report($sformatf("cell_char %0d, want %0d", cell_char, want.cell_char));
        if (cursor_pos !== want.cursor_pos)
          report($sformatf("cursor_pos %0d, want %0d", cursor_pos, want.cursor_pos));
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CMD_W-1:0]  command_i = CMD_WRITE;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic [ROW_W-1:0]  cell_row_i = '0;
  logic [COL_W-1:0]  cell_col_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CHAR_W-1:0] cell_char_o;
  logic [POS_W-1:0]  cursor_pos_o;

  text_screen_tracker screen = new();
  bit                 tx_quiet = 1'b0;
  bit                 rx_quiet = 1'b0;
  int                 idle_cycles = 0;

  text_buffer_cursor_scroll #(.ROWS(ROWS), .COLS(COLS)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .char_code_i  (char_code_i),
    .cell_row_i   (cell_row_i),
    .cell_col_i   (cell_col_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_char_o  (cell_char_o),
    .cursor_pos_o (cursor_pos_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 31) == 0) quiet = !quiet;
    return quiet ? 0 : int'($urandom_range(0, 14));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) screen.check_reply(cell_char_o, cursor_pos_o);
      if (in_valid_i && !in_stall_o)
        screen.note_request(command_i, char_code_i, cell_row_i, cell_col_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] code,
                              input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    int gap;
    gap = draw_wait(tx_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    char_code_i <= code;
    cell_row_i  <= row;
    cell_col_i  <= col;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (screen.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_traffic(input int count);
    int                r;
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] code;
    logic [COL_W-1:0]  col;
    for (int n = 0; n < count; n++) begin
      r    = int'($urandom_range(0, 999));
      code = CHAR_W'($urandom_range(0, 255));
      col  = COL_W'($urandom_range(0, 31));
      if (r < 3) begin
        cmd = CMD_CLEAR;
      end else if (r < 15) begin
        cmd = CMD_SPARE;
      end else if (r < 200) begin
        cmd = CMD_READ;
        if ($urandom_range(0, 9) != 0) col = COL_W'($urandom_range(0, COLS - 1));
      end else begin
        cmd = CMD_WRITE;
        if ($urandom_range(0, 7) == 0) code = NEWLINE_CODE;
      end
      send_request(cmd, code, ROW_W'($urandom_range(0, 3)), col);
      if (n == count / 2) hold_until_drained();
    end
  endtask

  initial begin
    forever begin
      int n;
      n = draw_wait(rx_quiet);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(CMD_READ, 8'h00, 2'd0, 5'd0);
    send_request(CMD_WRITE, 8'h00, 2'd3, 5'd31);
    send_request(CMD_WRITE, 8'hFF, 2'd0, 5'd0);
    send_request(CMD_WRITE, 8'h41, 2'd1, 5'd7);
    send_request(CMD_WRITE, NEWLINE_CODE, 2'd0, 5'd0);
    send_request(CMD_READ, 8'h00, 2'd0, 5'd0);
    send_request(CMD_READ, 8'h00, 2'd0, 5'd1);
    send_request(CMD_READ, 8'hFF, 2'd0, 5'd3);
    send_request(CMD_WRITE, NEWLINE_CODE, 2'd0, 5'd0);
    send_request(CMD_WRITE, 8'h7E, 2'd0, 5'd0);
    send_request(CMD_WRITE, NEWLINE_CODE, 2'd0, 5'd0);
    send_request(CMD_WRITE, NEWLINE_CODE, 2'd0, 5'd0);
    send_request(CMD_READ, 8'h00, 2'd3, 5'd20);
    send_request(CMD_WRITE, NEWLINE_CODE, 2'd0, 5'd0);
    send_request(CMD_WRITE, 8'h5A, 2'd0, 5'd0);
    send_request(CMD_READ, 8'h00, 2'd3, 5'd0);
    send_request(CMD_READ, 8'h00, 2'd1, 5'd0);
    send_request(CMD_READ, 8'h00, 2'd2, 5'd31);
    send_request(CMD_READ, 8'h00, 2'd1, 5'd21);
    send_request(CMD_SPARE, 8'hFF, 2'd3, 5'd31);
    send_request(CMD_CLEAR, 8'h00, 2'd0, 5'd0);
    send_request(CMD_READ, 8'h00, 2'd3, 5'd20);
    send_request(CMD_WRITE, 8'h80, 2'd0, 5'd0);
    send_request(CMD_READ, 8'h00, 2'd0, 5'd0);
    hold_until_drained();

    random_traffic(RANDOM_REQUESTS);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (screen.pending() != 0) screen.report("replies still outstanding at end");
    if (screen.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
